[hdl/wcat_pkg.sv]
package wcat_pkg;

  localparam int TableEntries = 1024;
  localparam int IdxW = $clog2(TableEntries);
  localparam int SumW = 40;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_MIX = 2'd1,
    CMD_FIN = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  entry_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [9:0] entry_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       used_default;
  } out_item_t;

  typedef struct packed {
    cmd_t            op;
    logic [IdxW-1:0] idx;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic [15:0]     weight;
  } job_t;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? SumMax : s[SumW-1:0];
  endfunction

endpackage

[hdl/wcat_if.sv]
interface wcat_in_if import wcat_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wcat_out_if import wcat_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wcat_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/weighted_color_average_table.sv]
// channel | dir | handshake       | payload
// in_ch   | in  | valid/ready     | cmd, entry_index, red..alpha, weight
// out_ch  | out | valid/ready     | entry_out, red_out..alpha_out, used_default
// cfg_ch  | in  | valid/ready     | fallback RGBA word
// Set and mix pass through the back end as queue pop, RAM read, then write.
// Finalize runs four serial divisions, one per channel, on one shared divider.
// After reset a clearing pass zeroes all 1024 table entries; items queue but
// are not executed until it ends. A 2-entry queue decouples input from back end;
// a held result blocks the back end only at the next finalize.
module weighted_color_average_table import wcat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wcat_in_if.sink    in_ch,
  wcat_out_if.source out_ch,
  wcat_cfg_if.sink   cfg_ch
);

  logic        job_valid;
  job_t        job;
  logic        job_pop;
  logic [31:0] fill_rgba;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) fill_rgba <= '0;
    else if (cfg_ch.valid) fill_rgba <= cfg_ch.data;
  end

  wcat_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .job_valid(job_valid), .job(job), .job_pop(job_pop)
  );

  wcat_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_pop(job_pop),
    .fill_rgba(fill_rgba), .out_ch(out_ch)
  );

endmodule

[hdl/wcat_front.sv]
module wcat_front import wcat_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  wcat_in_if.sink         in_ch,
  output logic            job_valid,
  output job_t            job,
  input  logic            job_pop
);

  job_t              q [QDepth];
  logic [0:0]        wr_ptr;
  logic [0:0]        rd_ptr;
  logic [1:0]        count;
  logic              keep;
  logic              push;
  logic [IdxW-1:0]   idx;

  assign idx = in_ch.data.entry_index[IdxW-1:0];
  assign keep = (in_ch.data.cmd != CMD_NOP) &&
                ({6'd0, in_ch.data.entry_index} < 16'(TableEntries));
  assign in_ch.ready = (count != 2'(QDepth));
  assign push = in_ch.valid && in_ch.ready && keep;
  assign job_valid = (count != 2'd0);
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: cmd_t'(in_ch.data.cmd), idx: idx, red: in_ch.data.red,
                     green: in_ch.data.green, blue: in_ch.data.blue,
                     alpha: in_ch.data.alpha, weight: in_ch.data.weight};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (job_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + {1'b0, push} - {1'b0, job_pop};
    end
  end

endmodule

[hdl/wcat_div.sv]
module wcat_div import wcat_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SumW-1:0] num,
  input  logic [SumW-1:0] den,
  output logic            done,
  output logic [7:0]      quo
);

  // restoring division, 9 quotient bits, one per cycle; q >= 256 saturates
  logic [SumW:0]   rem;
  logic [SumW-1:0] dreg;
  logic [8:0]      q;
  logic [3:0]      cnt;
  logic            busy;
  logic [SumW+8:0] sub;

  assign sub = {9'd0, dreg} << cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= {1'b0, num};
        dreg <= den;
        q    <= '0;
        cnt  <= 4'd8;
      end else if (busy) begin
        if ({8'd0, rem} >= sub) begin
          rem <= rem - sub[SumW:0];
          q   <= q | (9'd1 << cnt);
        end
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quo = q[8] ? 8'hFF : q[7:0];

endmodule

[hdl/wcat_back.sv]
module wcat_back import wcat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  input  logic [31:0] fill_rgba,
  wcat_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_READ, S_WRITE, S_DIV, S_WAIT, S_OUT
  } state_t;

  logic [SumW-1:0] mem_c [4][TableEntries];
  logic [SumW-1:0] mem_w [TableEntries];
  logic [SumW-1:0] rd_c [4];
  logic [SumW-1:0] rd_w;

  state_t          state;
  logic [IdxW:0]   clr;
  job_t            cur;
  logic [1:0]      ch;
  logic            dstart;
  logic            ddone;
  logic [7:0]      dquo;
  logic [7:0]      res [4];
  logic            res_dflt;
  logic [7:0]      col [4];
  logic [SumW-1:0] prod [4];

  assign col[0] = cur.red;
  assign col[1] = cur.green;
  assign col[2] = cur.blue;
  assign col[3] = cur.alpha;

  always_comb begin
    for (int i = 0; i < 4; i++) prod[i] = SumW'(col[i] * cur.weight);
  end

  wcat_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(rd_c[ch]), .den(rd_w),
    .done(ddone), .quo(dquo)
  );

  assign job_pop = (state == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    rd_w <= mem_w[cur.idx];
    for (int i = 0; i < 4; i++) rd_c[i] <= mem_c[i][cur.idx];
    if (state == S_CLEAR) begin
      mem_w[clr[IdxW-1:0]] <= '0;
      for (int i = 0; i < 4; i++) mem_c[i][clr[IdxW-1:0]] <= '0;
    end else if (state == S_WRITE) begin
      if (cur.op == CMD_SET) begin
        mem_w[cur.idx] <= SumW'(cur.weight);
        for (int i = 0; i < 4; i++) mem_c[i][cur.idx] <= prod[i];
      end else begin
        mem_w[cur.idx] <= sat_add(rd_w, SumW'(cur.weight));
        for (int i = 0; i < 4; i++) mem_c[i][cur.idx] <= sat_add(rd_c[i], prod[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_ch.valid <= 1'b0;
      dstart <= 1'b0;
      ch <= '0;
    end else begin
      dstart <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (IdxW+1)'(TableEntries - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            state <= S_READ;
          end
        end
        S_READ: state <= (cur.op == CMD_FIN) ? S_DIV : S_WRITE;
        S_WRITE: state <= S_IDLE;
        S_DIV: begin
          if (rd_w == '0) begin
            for (int i = 0; i < 4; i++) res[i] <= fill_rgba[8*i +: 8];
            res_dflt <= 1'b1;
            state <= S_OUT;
          end else begin
            res_dflt <= 1'b0;
            ch <= '0;
            dstart <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (ddone) begin
            res[ch] <= dquo;
            ch <= ch + 1'b1;
            if (ch == 2'd3) state <= S_OUT;
            else dstart <= 1'b1;
          end
        end
        S_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.data.entry_out <= 10'(cur.idx);
            out_ch.data.red_out <= res[0];
            out_ch.data.green_out <= res[1];
            out_ch.data.blue_out <= res[2];
            out_ch.data.alpha_out <= res[3];
            out_ch.data.used_default <= res_dflt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

endmodule

[test/tb_top.sv]
module tb_top;
  import wcat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 250000;
  localparam int DrainCycles = 80;
  localparam int LongHold = 400;

  class avg_tracker;
    logic [SumW-1:0] chan[TableEntries][4];
    logic [SumW-1:0] wsum[TableEntries];
    logic [31:0] dflt;
    out_item_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < TableEntries; i++) begin
        wsum[i] = '0;
        for (int c = 0; c < 4; c++) chan[i][c] = '0;
      end
      dflt = '0;
      errors = 0;
    endfunction

    function logic [SumW-1:0] add_clip(logic [SumW-1:0] a, logic [SumW-1:0] b);
      logic [SumW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SumW] ? SumMax : s[SumW-1:0];
    endfunction

    function void note_item(in_item_t it);
      logic [7:0] col[4];
      logic [SumW-1:0] prod;
      logic [SumW-1:0] q;
      out_item_t r;
      col[0] = it.red; col[1] = it.green; col[2] = it.blue; col[3] = it.alpha;
      if (it.cmd == CMD_NOP || it.entry_index >= TableEntries) return;
      case (it.cmd)
        CMD_SET: begin
          for (int c = 0; c < 4; c++) chan[it.entry_index][c] = SumW'(col[c]) * it.weight;
          wsum[it.entry_index] = SumW'(it.weight);
        end
        CMD_MIX: begin
          for (int c = 0; c < 4; c++) begin
            prod = SumW'(col[c]) * it.weight;
            chan[it.entry_index][c] = add_clip(chan[it.entry_index][c], prod);
          end
          wsum[it.entry_index] = add_clip(wsum[it.entry_index], SumW'(it.weight));
        end
        default: begin
          r.entry_out = it.entry_index;
          if (wsum[it.entry_index] == 0) begin
            {r.alpha_out, r.blue_out, r.green_out, r.red_out} = dflt;
            r.used_default = 1'b1;
          end else begin
            for (int c = 0; c < 4; c++) begin
              q = chan[it.entry_index][c] / wsum[it.entry_index];
              col[c] = (q > 255) ? 8'hFF : q[7:0];
            end
            {r.red_out, r.green_out, r.blue_out, r.alpha_out} = {col[0], col[1], col[2], col[3]};
            r.used_default = 1'b0;
          end
          pending.push_back(r);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result entry_out=%0d", got.entry_out);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.entry_out !== e.entry_out) begin
        $error("entry_out exp %0d got %0d", e.entry_out, got.entry_out); errors++;
      end
      if (got.red_out !== e.red_out) begin
        $error("red_out exp %0d got %0d", e.red_out, got.red_out); errors++;
      end
      if (got.green_out !== e.green_out) begin
        $error("green_out exp %0d got %0d", e.green_out, got.green_out); errors++;
      end
      if (got.blue_out !== e.blue_out) begin
        $error("blue_out exp %0d got %0d", e.blue_out, got.blue_out); errors++;
      end
      if (got.alpha_out !== e.alpha_out) begin
        $error("alpha_out exp %0d got %0d", e.alpha_out, got.alpha_out); errors++;
      end
      if (got.used_default !== e.used_default) begin
        $error("used_default exp %0d got %0d", e.used_default, got.used_default); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int cycles;
  int hold_req;
  int hold_done;
  avg_tracker sb;

  wcat_in_if  in_ch ();
  wcat_out_if out_ch ();
  wcat_cfg_if cfg_ch ();

  weighted_color_average_table dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // receiver: own stall pattern plus requested long hold-offs
  initial begin
    int mode;
    int left;
    out_ch.ready <= 1'b0;
    mode = 0;
    left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (hold_req != hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_done = hold_req;
        out_ch.ready <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(5, 60);
        end
        left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 1) != 0);
          default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic send(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  task automatic pause(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pause(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_default(logic [31:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.dflt = v;
  endtask

  function automatic in_item_t mk(logic [1:0] cmd, logic [9:0] idx, logic [31:0] rgba,
                                  logic [15:0] w);
    in_item_t it;
    it.cmd = cmd;
    it.entry_index = idx;
    {it.red, it.green, it.blue, it.alpha} = rgba;
    it.weight = w;
    return it;
  endfunction

  function automatic in_item_t rnd_item(logic [1:0] cmd, logic [9:0] idx);
    logic [15:0] w;
    case ($urandom_range(0, 4))
      0: w = 16'hFFFF;
      1: w = 16'd0;
      2: w = 16'($urandom_range(1, 8));
      default: w = 16'($urandom_range(0, 65535));
    endcase
    return mk(cmd, idx, $urandom, w);
  endfunction

  // bursts of random length with random gaps; some stretches without gaps
  task automatic run_phase(int n_items);
    logic [9:0] pool[8];
    int burst;
    int gapmax;
    int sent;
    int k;
    logic [9:0] idx;
    for (int i = 0; i < 8; i++) pool[i] = 10'($urandom_range(0, TableEntries - 1));
    pool[0] = 10'd0;
    pool[1] = 10'd1023;
    sent = 0;
    burst = 0;
    gapmax = 0;
    while (sent < n_items) begin
      if (burst == 0) begin
        if (gapmax > 0) pause($urandom_range(1, gapmax));
        burst = $urandom_range(1, 20);
        gapmax = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if ($urandom_range(0, 9) < 8) begin
        idx = pool[$urandom_range(0, 7)];
        send(rnd_item(CMD_SET, idx));
        k = $urandom_range(0, 4);
        for (int j = 0; j < k; j++) send(rnd_item(CMD_MIX, idx));
        send(rnd_item(CMD_FIN, idx));
        sent += k + 2;
      end else begin
        send(rnd_item(2'($urandom_range(0, 3)),
                      10'($urandom_range(0, TableEntries - 1))));
        sent++;
      end
      burst--;
    end
  endtask

  initial begin
    sb = new();
    hold_req = 0;
    hold_done = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset defaults, extremes, zero weight, ignored command
    send(mk(CMD_FIN, 10'd0, 32'h0, 16'h0));
    send(mk(CMD_FIN, 10'd1023, 32'h0, 16'h0));
    write_default(32'hFFFFFFFF);
    send(mk(CMD_FIN, 10'd5, 32'h0, 16'h0));
    send(mk(CMD_SET, 10'd1023, 32'hFFFFFFFF, 16'hFFFF));
    send(mk(CMD_FIN, 10'd1023, 32'h0, 16'h0));
    send(mk(CMD_MIX, 10'd1023, 32'h00000000, 16'hFFFF));
    send(mk(CMD_FIN, 10'd1023, 32'hFFFFFFFF, 16'hFFFF));
    send(mk(CMD_SET, 10'd0, 32'h80FF0001, 16'd1));
    send(mk(CMD_MIX, 10'd0, 32'h7F00FF02, 16'h8000));
    send(mk(CMD_MIX, 10'd0, 32'hFFFFFFFF, 16'h7FFF));
    send(mk(CMD_FIN, 10'd0, 32'h0, 16'h0));
    send(mk(CMD_SET, 10'd0, 32'h12345678, 16'h0));
    send(mk(CMD_FIN, 10'd0, 32'h0, 16'h0));
    send(mk(CMD_MIX, 10'd0, 32'h0, 16'h0));
    send(mk(CMD_FIN, 10'd0, 32'h0, 16'h0));
    send(mk(CMD_NOP, 10'd0, 32'hFFFFFFFF, 16'hFFFF));
    send(mk(CMD_NOP, 10'd1023, 32'h0, 16'h0));
    send(mk(CMD_FIN, 10'd0, 32'h0, 16'h0));
    write_default(32'h00000000);
    send(mk(CMD_FIN, 10'd0, 32'h0, 16'h0));
    send(mk(CMD_MIX, 10'd0, 32'hFFFFFFFF, 16'd1));
    send(mk(CMD_FIN, 10'd0, 32'h0, 16'h0));

    write_default(32'hA5C3_1E7F);
    run_phase(110);
    write_default(32'hFFFFFFFF);
    hold_req++;
    run_phase(110);
    write_default($urandom);
    run_phase(110);
    write_default(32'h00000000);
    run_phase(110);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
